/* hdl/pidr_pkg.sv */
// Shared types and constants for the pulse interval dice roller.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package pidr_pkg;

  localparam int EDGE_TIME_W  = 32;
  localparam int DIE_SIZE_W   = 16;
  localparam int DIE_COUNT_W  = 7;
  localparam int ROLL_VALUE_W = 16;
  localparam int STATUS_W     = 2;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_ROLL = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ROLL    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One queued job for the back end: a single result, or a burst of
  // ones for a die of size one.
  typedef struct packed {
    logic                    burst;
    logic [DIE_COUNT_W-1:0]  count;
    logic [STATUS_W-1:0]     status;
    logic [ROLL_VALUE_W-1:0] value;
    logic                    last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* hdl/pidr_if.sv */
// Valid/ready channel interfaces for request words and result words.
// Depends on pidr_pkg for the field widths.
`default_nettype none

interface pidr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [pidr_pkg::EDGE_TIME_W-1:0]   edge_time;
  logic [pidr_pkg::DIE_SIZE_W-1:0]    die_size;
  logic [pidr_pkg::DIE_COUNT_W-1:0]   die_count;

  modport source (output valid, op, edge_time, die_size, die_count, input ready);
  modport sink (input valid, op, edge_time, die_size, die_count, output ready);
endinterface

interface pidr_out_if;
  logic                               valid;
  logic                               ready;
  logic [pidr_pkg::STATUS_W-1:0]      status;
  logic [pidr_pkg::ROLL_VALUE_W-1:0]  roll_value;
  logic                               last;

  modport source (output valid, status, roll_value, last, input ready);
  modport sink (input valid, status, roll_value, last, output ready);
endinterface

`default_nettype wire

/* hdl/pidr_front.sv */
// Front end: accepts request and edge words, tracks the bit extraction
// state and pushes result jobs into the queue. Depends on pidr_pkg, pidr_if.
`default_nettype none

module pidr_front #(
  parameter int MAX_DICE  = 64,
  parameter int SIZE_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  pidr_in_if.sink                  item,
  input  wire pidr_pkg::q_status_t q_stat,
  output      logic                push,
  output      pidr_pkg::job_t      push_job
);
  import pidr_pkg::*;

  localparam int NW = $clog2(SIZE_BITS + 1);

  logic                   busy, busy_next;
  logic                   sync_pending, sync_pending_next;
  logic                   edge_phase, edge_phase_next;
  logic                   have_first, have_first_next;
  logic [TIME_BITS-1:0]   pair_start, pair_start_next;
  logic [TIME_BITS-1:0]   first_interval, first_interval_next;
  logic [SIZE_BITS-1:0]   accumulator, accumulator_next;
  logic [NW-1:0]          collected, collected_next;
  logic [NW-1:0]          needed, needed_next;
  logic [SIZE_BITS-1:0]   active_size, active_size_next;
  logic [DIE_COUNT_W-1:0] remaining, remaining_next;

  logic                   accept;
  logic [TIME_BITS-1:0]   t;
  logic [TIME_BITS-1:0]   interval;
  logic [SIZE_BITS-1:0]   size;
  logic [DIE_COUNT_W-1:0] count;
  logic [SIZE_BITS-1:0]   acc_shift;
  logic [NW-1:0]          coll_inc;
  logic [DIE_COUNT_W-1:0] rem_dec;

  function automatic logic [NW-1:0] width_for(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] sm1;
    logic [NW-1:0]        n;
    sm1 = s - SIZE_BITS'(1);
    n = '0;
    for (int i = 0; i < SIZE_BITS; i++) begin
      if (sm1[i]) begin
        n = NW'(i + 1);
      end
    end
    return n;
  endfunction

  assign item.ready = !q_stat.full;
  assign accept     = item.valid && item.ready;
  assign t          = item.edge_time[TIME_BITS-1:0];
  assign size       = item.die_size[SIZE_BITS-1:0];
  assign count      = (item.die_count > DIE_COUNT_W'(MAX_DICE)) ?
                      DIE_COUNT_W'(MAX_DICE) : item.die_count;
  assign interval   = t - pair_start;
  assign acc_shift  = {accumulator[SIZE_BITS-2:0], (first_interval < interval)};
  assign coll_inc   = collected + NW'(1);
  assign rem_dec    = remaining - DIE_COUNT_W'(1);

  always_comb begin
    busy_next           = busy;
    sync_pending_next   = sync_pending;
    edge_phase_next     = edge_phase;
    have_first_next     = have_first;
    pair_start_next     = pair_start;
    first_interval_next = first_interval;
    accumulator_next    = accumulator;
    collected_next      = collected;
    needed_next         = needed;
    active_size_next    = active_size;
    remaining_next      = remaining;
    push                = 1'b0;
    push_job            = '{burst: 1'b0, count: '0, status: STATUS_ROLL,
                            value: '0, last: 1'b1};
    if (accept) begin
      if (item.op == OP_ROLL) begin
        if (busy) begin
          push            = 1'b1;
          push_job.status = STATUS_REFUSED;
        end else if (count == '0 || size == '0) begin
          push            = 1'b1;
          push_job.status = STATUS_EMPTY;
        end else if (size == SIZE_BITS'(1)) begin
          push           = 1'b1;
          push_job.burst = 1'b1;
          push_job.count = count;
          push_job.value = ROLL_VALUE_W'(1);
        end else begin
          busy_next         = 1'b1;
          sync_pending_next = 1'b1;
          edge_phase_next   = 1'b0;
          have_first_next   = 1'b0;
          accumulator_next  = '0;
          collected_next    = '0;
          needed_next       = width_for(size);
          active_size_next  = size;
          remaining_next    = count;
        end
      end else if (busy) begin
        if (sync_pending) begin
          sync_pending_next = 1'b0;
        end else if (!edge_phase) begin
          pair_start_next = t;
          edge_phase_next = 1'b1;
        end else begin
          edge_phase_next = 1'b0;
          if (!have_first) begin
            first_interval_next = interval;
            have_first_next     = 1'b1;
          end else begin
            have_first_next = 1'b0;
            if (first_interval != interval) begin
              if (coll_inc >= needed) begin
                accumulator_next = '0;
                collected_next   = '0;
                if (acc_shift < active_size) begin
                  remaining_next = rem_dec;
                  busy_next      = (rem_dec != '0);
                  push           = 1'b1;
                  push_job.value = ROLL_VALUE_W'(acc_shift) + ROLL_VALUE_W'(1);
                  push_job.last  = (rem_dec == '0);
                end
              end else begin
                accumulator_next = acc_shift;
                collected_next   = coll_inc;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      sync_pending <= 1'b0;
      edge_phase   <= 1'b0;
      have_first   <= 1'b0;
      collected    <= '0;
      remaining    <= '0;
    end else begin
      busy         <= busy_next;
      sync_pending <= sync_pending_next;
      edge_phase   <= edge_phase_next;
      have_first   <= have_first_next;
      collected    <= collected_next;
      remaining    <= remaining_next;
    end
    pair_start     <= pair_start_next;
    first_interval <= first_interval_next;
    accumulator    <= accumulator_next;
    needed         <= needed_next;
    active_size    <= active_size_next;
  end

endmodule

`default_nettype wire

/* hdl/pidr_queue.sv */
// Short job queue between the front end and the back end.
// Depends on pidr_pkg for the job type and depth.
`default_nettype none

module pidr_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pidr_pkg::job_t      push_job,
  input  wire logic                pop,
  output      pidr_pkg::job_t      head,
  output      pidr_pkg::q_status_t q_stat
);
  import pidr_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QUEUE_AW + 1)'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* hdl/pidr_back.sv */
// Back end: expands queued jobs into result words and holds the output register.
// Depends on pidr_pkg and pidr_if.
`default_nettype none

module pidr_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pidr_pkg::job_t      head,
  input  wire pidr_pkg::q_status_t q_stat,
  output      logic                pop,
  pidr_out_if.source               result
);
  import pidr_pkg::*;

  logic [DIE_COUNT_W-1:0] burst_idx;
  logic                   emit;
  logic                   burst_end;

  assign emit      = !q_stat.empty && (!result.valid || result.ready);
  assign burst_end = (burst_idx + DIE_COUNT_W'(1)) == head.count;
  assign pop       = emit && (!head.burst || burst_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      burst_idx    <= '0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
        if (head.burst) begin
          burst_idx <= burst_end ? '0 : burst_idx + DIE_COUNT_W'(1);
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
    if (emit) begin
      result.status     <= head.status;
      result.roll_value <= head.value;
      result.last       <= head.burst ? burst_end : head.last;
    end
  end

endmodule

`default_nettype wire

/* hdl/pulse_interval_dice_roller.sv */
// Top level: one word is accepted per cycle while the job queue has room;
// a result job enters the queue at the edge that accepts its word.
// Results leave one per cycle while the output is ready; so do size-one dice.
// The output register and the four-entry job queue set these figures.
// Synchronous active-high reset empties the queue and clears the roll state.
`default_nettype none

module pulse_interval_dice_roller #(
  parameter int MAX_DICE  = 64,
  parameter int SIZE_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  pidr_in_if.sink    item,
  pidr_out_if.source result
);
  import pidr_pkg::*;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t q_stat;

  pidr_front #(
    .MAX_DICE  (MAX_DICE),
    .SIZE_BITS (SIZE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  pidr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  pidr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("output valid after reset");
  a_special_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != STATUS_ROLL) |->
    (result.roll_value == '0 && result.last))
    else $error("refused or empty result with bad fields");
  a_roll_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_ROLL) |-> result.roll_value != '0)
    else $error("die result of zero");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("job pushed into full queue");
`endif

endmodule

`default_nettype wire
